>>> rtl/core/bde_pkg.sv
package bde_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed port widths
  localparam int ACTION_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

  // Action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd6;

  // Command kinds after classification
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

  // One classified command
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               to_front;  // logical side for push and pop
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

>>> rtl/core/bde_front.sv
module bde_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bde_pkg::ACTION_W-1:0]  action,
  input  logic [bde_pkg::VALUE_W-1:0]   value,
  output logic                          cmd_valid,
  output bde_pkg::cmd_t                 cmd,
  input  logic                          cmd_take
);

  bde_pkg::cmd_t                      q [bde_pkg::QUEUE_DEPTH];
  logic [bde_pkg::QUEUE_PTR_W-1:0]    wp;
  logic [bde_pkg::QUEUE_PTR_W-1:0]    rp;
  logic [bde_pkg::QUEUE_FILL_W-1:0]   fill;
  logic                               push;
  bde_pkg::cmd_t                      decoded;

  // Classify one beat into a command kind and logical side
  always_comb begin
    decoded.value    = value;
    decoded.to_front = 1'b0;
    case (action)
      bde_pkg::ACT_PUSH_FRONT: begin
        decoded.kind     = bde_pkg::KIND_PUSH;
        decoded.to_front = 1'b1;
      end
      bde_pkg::ACT_PUSH_BACK: begin
        decoded.kind = bde_pkg::KIND_PUSH;
      end
      bde_pkg::ACT_POP_FRONT: begin
        decoded.kind     = bde_pkg::KIND_POP;
        decoded.to_front = 1'b1;
      end
      bde_pkg::ACT_POP_BACK: begin
        decoded.kind = bde_pkg::KIND_POP;
      end
      bde_pkg::ACT_REMOVE:  decoded.kind = bde_pkg::KIND_REMOVE;
      bde_pkg::ACT_REVERSE: decoded.kind = bde_pkg::KIND_REVERSE;
      bde_pkg::ACT_CLEAR:   decoded.kind = bde_pkg::KIND_CLEAR;
      default:              decoded.kind = bde_pkg::KIND_NONE;
    endcase
  end

  assign in_stall  = (fill == bde_pkg::QUEUE_FILL_W'(bde_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rp];

  // Command queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= decoded;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == bde_pkg::QUEUE_PTR_W'(bde_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (cmd_take) begin
        rp <= (rp == bde_pkg::QUEUE_PTR_W'(bde_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !cmd_take) begin
        fill <= fill + 1'b1;
      end else if (!push && cmd_take) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bde_back.sv
module bde_back #(
  parameter int CAPACITY   = bde_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = bde_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  bde_pkg::cmd_t                    cmd,
  output logic                             cmd_take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             ok,
  output logic [bde_pkg::VALUE_W-1:0]      popped_value,
  output logic [bde_pkg::COUNT_OUT_W-1:0]  removed_count,
  output logic [bde_pkg::COUNT_OUT_W-1:0]  length,
  output logic [bde_pkg::VALUE_W-1:0]      front_value,
  output logic [bde_pkg::VALUE_W-1:0]      back_value,
  output logic                             not_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  // Ring slot of an offset from the head
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  logic [1:0]            state, state_next;
  logic [IW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic                  rev, rev_next;
  logic                  ok_q, ok_next;
  logic [DATA_WIDTH-1:0] popped_q, popped_next;
  logic [CW-1:0]         removed_q, removed_next;
  logic                  res_valid, res_valid_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  logic [CW-1:0]         rd_off, rd_off_next;
  logic [CW-1:0]         wr_off, wr_off_next;
  logic                  rv, rv_next;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd0, rd1;
  logic                  we, re0, re1, rd_zero;
  logic [IW-1:0]         waddr, raddr0, raddr1;
  logic [DATA_WIDTH-1:0] wdata;

  logic                  out_free;
  logic                  full, empty, phys_low;
  logic [CW-1:0]         last_off;
  logic [IW-1:0]         head_dec, head_inc, last_slot;
  logic [63:0]           in64;
  logic [DATA_WIDTH-1:0] cmd_data;
  logic [63:0]           pop64, front64, back64;
  logic [31:0]           len32, rem32;

  assign in64     = 64'(cmd.value);
  assign cmd_data = in64[DATA_WIDTH-1:0];

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign phys_low  = cmd.to_front ^ rev;
  assign last_off  = count - 1'b1;
  assign last_slot = slot_of(head, last_off);
  assign head_dec  = (head == '0) ? IW'(CAPACITY - 1) : head - 1'b1;
  assign head_inc  = (head == IW'(CAPACITY - 1)) ? '0 : head + 1'b1;

  assign out_free = !res_valid || !out_stall;
  assign cmd_take = (state == ST_IDLE) && cmd_valid && out_free;

  // Sequencer: execute on take, walk for remove, then report
  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    rev_next       = rev;
    ok_next        = ok_q;
    popped_next    = popped_q;
    removed_next   = removed_q;
    res_valid_next = res_valid;
    key_next       = key;
    rd_off_next    = rd_off;
    wr_off_next    = wr_off;
    rv_next        = rv;
    we             = 1'b0;
    waddr          = head;
    wdata          = cmd_data;
    re0            = 1'b0;
    re1            = 1'b0;
    raddr0         = head;
    raddr1         = head;
    rd_zero        = 1'b0;

    if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          ok_next      = 1'b1;
          popped_next  = '0;
          removed_next = '0;
          state_next   = ST_REPORT;
          case (cmd.kind)
            bde_pkg::KIND_PUSH: begin
              if (full) begin
                ok_next = 1'b0;
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
                if (phys_low) begin
                  head_next = head_dec;
                  waddr     = head_dec;
                end else begin
                  waddr = slot_of(head, count);
                end
              end
            end
            bde_pkg::KIND_POP: begin
              if (empty) begin
                ok_next = 1'b0;
              end else begin
                // front/back of the last report mirror the current ends
                popped_next = cmd.to_front ? rd0 : rd1;
                count_next  = count - 1'b1;
                if (phys_low) begin
                  head_next = head_inc;
                end
              end
            end
            bde_pkg::KIND_REMOVE: begin
              key_next    = cmd_data;
              rd_off_next = '0;
              wr_off_next = '0;
              rv_next     = 1'b0;
              state_next  = ST_WALK;
            end
            bde_pkg::KIND_REVERSE: begin
              if (!empty) begin
                rev_next = !rev;
              end
            end
            bde_pkg::KIND_CLEAR: begin
              head_next  = '0;
              count_next = '0;
              rev_next   = 1'b0;
            end
            default: begin
              ok_next = 1'b0;
            end
          endcase
        end
      end

      ST_WALK: begin
        // Read one slot a cycle, pack survivors toward the head
        if (rd_off != count) begin
          re0         = 1'b1;
          raddr0      = slot_of(head, rd_off);
          rd_off_next = rd_off + 1'b1;
          rv_next     = 1'b1;
        end else begin
          rv_next = 1'b0;
        end
        if (rv && (rd0 != key)) begin
          we          = 1'b1;
          waddr       = slot_of(head, wr_off);
          wdata       = rd0;
          wr_off_next = wr_off + 1'b1;
        end
        if ((rd_off == count) && !rv) begin
          count_next   = wr_off;
          removed_next = count - wr_off;
          state_next   = ST_REPORT;
        end
      end

      ST_REPORT: begin
        re0            = 1'b1;
        re1            = 1'b1;
        rd_zero        = empty;
        raddr0         = rev ? last_slot : head;
        raddr1         = rev ? head : last_slot;
        res_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ring store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rd0 <= rd_zero ? '0 : mem[raddr0];
    end
    if (re1) begin
      rd1 <= rd_zero ? '0 : mem[raddr1];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rev       <= 1'b0;
      res_valid <= 1'b0;
      rd_off    <= '0;
      wr_off    <= '0;
      rv        <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      rev       <= rev_next;
      res_valid <= res_valid_next;
      rd_off    <= rd_off_next;
      wr_off    <= wr_off_next;
      rv        <= rv_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    ok_q      <= ok_next;
    popped_q  <= popped_next;
    removed_q <= removed_next;
    key       <= key_next;
  end

  // Result fields
  assign pop64   = 64'(popped_q);
  assign front64 = 64'(rd0);
  assign back64  = 64'(rd1);
  assign len32   = 32'(count);
  assign rem32   = 32'(removed_q);

  assign out_valid     = res_valid;
  assign ok            = ok_q;
  assign popped_value  = pop64[bde_pkg::VALUE_W-1:0];
  assign removed_count = rem32[bde_pkg::COUNT_OUT_W-1:0];
  assign length        = len32[bde_pkg::COUNT_OUT_W-1:0];
  assign front_value   = front64[bde_pkg::VALUE_W-1:0];
  assign back_value    = back64[bde_pkg::VALUE_W-1:0];
  assign not_empty     = !empty;

`ifndef SYNTHESIS
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(CAPACITY)) && (head <= IW'(CAPACITY - 1)))
    else $error("ring pointers out of range");

  a_rose_after_report: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_REPORT))
    else $error("result raised outside report cycle");

  a_no_take_while_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |-> !cmd_take)
    else $error("command taken while result is held");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (wr_off <= rd_off))
    else $error("compaction write passed read");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && (cmd.kind == bde_pkg::KIND_CLEAR)) |=> ((count == '0) && !rev))
    else $error("clear left elements");
`endif

endmodule

>>> rtl/core/bounded_deque_engine.sv
// Double-ended queue of up to CAPACITY elements of DATA_WIDTH bits in a ring
// store, with one result beat per input beat. An input queue of two beats sits
// in front of the execution sequencer, so input beats are taken while a result
// waits. Push, pop, reverse, clear and unknown actions first update the ring,
// then read the new front and back through the store's two read ports. Remove
// matching walks the store one slot per cycle. The ring store has no clearing
// pass after reset; only occupied slots are ever read.
module bounded_deque_engine #(
  parameter int CAPACITY   = bde_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = bde_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bde_pkg::ACTION_W-1:0]     action,
  input  logic [bde_pkg::VALUE_W-1:0]      value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             ok,
  output logic [bde_pkg::VALUE_W-1:0]      popped_value,
  output logic [bde_pkg::COUNT_OUT_W-1:0]  removed_count,
  output logic [bde_pkg::COUNT_OUT_W-1:0]  length,
  output logic [bde_pkg::VALUE_W-1:0]      front_value,
  output logic [bde_pkg::VALUE_W-1:0]      back_value,
  output logic                             not_empty
);

  logic          cmd_valid;
  logic          cmd_take;
  bde_pkg::cmd_t cmd;

  bde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  bde_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .popped_value  (popped_value),
    .removed_count (removed_count),
    .length        (length),
    .front_value   (front_value),
    .back_value    (back_value),
    .not_empty     (not_empty)
  );

endmodule
